@@ rtl/ctsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsa_pkg: shared types and constants of the cell tensor scatter-accumulator
// Register indexes, request codes, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package ctsa_pkg;

	localparam int unsigned NUM_COMP = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELLS_X = 3'd0,
		REG_CELLS_Y = 3'd1,
		REG_CELLS_Z = 3'd2,
		REG_BOX_X   = 3'd3,
		REG_BOX_Y   = 3'd4,
		REG_BOX_Z   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_ACCUM = 1'b0,
		REQ_READ  = 1'b1
	} req_type_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic               is_read;
		logic               bad;
		logic [15:0]        cell_num;
		logic signed [31:0] dl_x;
		logic signed [31:0] dl_y;
		logic signed [31:0] dl_z;
		logic signed [17:0] b_x;
		logic signed [17:0] b_y;
		logic signed [17:0] b_z;
	} job_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_READ,
		ST_CLEAR
	} bstate_t;

	// Minimum-image correction of one component
	function automatic logic signed [31:0] image1(input logic signed [31:0] d,
			input logic [31:0] len);
		logic signed [33:0] d2;
		logic signed [33:0] l;
		logic signed [33:0] r;
		begin
			d2 = {{2{d[31]}}, d} <<< 1;
			l  = {2'b00, len};
			r  = {{2{d[31]}}, d};
			if (len != 32'd0) begin
				if (d2 > l) r = r - l;
				else if (d2 < -l) r = r + l;
			end
			image1 = r[31:0];
		end
	endfunction

	// Saturating signed 64-bit add
	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			else sat_add = s[63:0];
		end
	endfunction

endpackage

@@ rtl/ctsa_if.sv @@
// ----------------------------------------------------------------------------
// ctsa_req_if / ctsa_rsp_if: valid/ready channels of the accumulator
// Request channel carries a segment or readout request; reply carries one entry.
// ----------------------------------------------------------------------------
interface ctsa_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [3:0]         cell_x;
	logic [3:0]         cell_y;
	logic [3:0]         cell_z;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic signed [31:0] delta_z;
	logic signed [17:0] burg_x;
	logic signed [17:0] burg_y;
	logic signed [17:0] burg_z;
	modport source (output valid, req_type, cell_x, cell_y, cell_z, delta_x, delta_y,
		delta_z, burg_x, burg_y, burg_z, input ready);
	modport sink (input valid, req_type, cell_x, cell_y, cell_z, delta_x, delta_y,
		delta_z, burg_x, burg_y, burg_z, output ready);
endinterface

interface ctsa_rsp_if;
	logic               valid;
	logic               ready;
	logic [11:0]        cell_number;
	logic [3:0]         component;
	logic signed [63:0] tensor_value;
	logic               bad_cell;
	logic               last;
	modport source (output valid, cell_number, component, tensor_value, bad_cell, last,
		input ready);
	modport sink (input valid, cell_number, component, tensor_value, bad_cell, last,
		output ready);
endinterface

@@ rtl/ctsa_front.sv @@
// ----------------------------------------------------------------------------
// ctsa_front: request intake and classification
// Checks the cell against the grid, forms the cell number, images the vector.
// ----------------------------------------------------------------------------
module ctsa_front #(
	parameter int unsigned MAX_CELLS = 4096,
	parameter int unsigned DIM_MAX   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	ctsa_req_if.sink           req,
	input  logic [4:0]         cells_x,
	input  logic [4:0]         cells_y,
	input  logic [4:0]         cells_z,
	input  logic [31:0]        box_x,
	input  logic [31:0]        box_y,
	input  logic [31:0]        box_z,
	output logic               job_valid,
	output ctsa_pkg::job_t     job,
	input  logic               job_ready
);

	logic [4:0] nx, ny, nz;
	logic [4:0] dmax;
	logic [9:0] nzy;
	logic [16:0] cell_full;
	logic bad_idx;
	logic bad;
	ctsa_pkg::job_t job_d;
	logic valid_s1;
	ctsa_pkg::job_t job_s1;

	// counts never exceed 31, so a larger grid limit acts as 31
	assign dmax = 5'((DIM_MAX > 31) ? 31 : DIM_MAX);
	assign nx = (cells_x > dmax) ? dmax : cells_x;
	assign ny = (cells_y > dmax) ? dmax : cells_y;
	assign nz = (cells_z > dmax) ? dmax : cells_z;

	// Grid check and linear cell number (narrow products)
	always_comb begin
		nzy = 10'(nz) * 10'(ny);
		cell_full = 17'(req.cell_z) + 17'(nz) * 17'(req.cell_y)
			+ 17'(nzy) * 17'(req.cell_x);
		bad_idx = ({1'b0, req.cell_x} >= nx) || ({1'b0, req.cell_y} >= ny)
			|| ({1'b0, req.cell_z} >= nz);
		bad = bad_idx || (cell_full >= 17'(MAX_CELLS));
		job_d.is_read  = (req.req_type == ctsa_pkg::REQ_READ);
		job_d.bad      = bad;
		job_d.cell_num = bad ? 16'd0 : cell_full[15:0];
		job_d.dl_x     = ctsa_pkg::image1(req.delta_x, box_x);
		job_d.dl_y     = ctsa_pkg::image1(req.delta_y, box_y);
		job_d.dl_z     = ctsa_pkg::image1(req.delta_z, box_z);
		job_d.b_x      = req.burg_x;
		job_d.b_y      = req.burg_y;
		job_d.b_z      = req.burg_z;
	end

	assign req.ready = !valid_s1 || job_ready;

	// Output register of the front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (req.ready) valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) job_s1 <= job_d;
	end

	assign job_valid = valid_s1;
	assign job = job_s1;

endmodule

@@ rtl/ctsa_queue.sv @@
// ----------------------------------------------------------------------------
// ctsa_queue: short FIFO between front and back
// Two-entry queue of classified requests.
// ----------------------------------------------------------------------------
module ctsa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ctsa_pkg::job_t in_job,
	output logic           in_ready,
	output logic           out_valid,
	output ctsa_pkg::job_t out_job,
	input  logic           out_ready
);

	ctsa_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

endmodule

@@ rtl/ctsa_back.sv @@
// ----------------------------------------------------------------------------
// ctsa_back: tensor store and accumulate / readout sequencer
// Accumulates one component per cycle: registered product, read-modify-write
// ----------------------------------------------------------------------------
module ctsa_back #(
	parameter int unsigned MAX_CELLS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  ctsa_pkg::job_t job,
	output logic           job_ready,
	ctsa_rsp_if.source     rsp
);

	localparam int unsigned DEPTH = MAX_CELLS * ctsa_pkg::NUM_COMP;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic signed [63:0] mem [DEPTH];

	ctsa_pkg::bstate_t state_q, state_d;
	ctsa_pkg::job_t    cur_q;
	logic [3:0]        comp_q;
	logic [AW:0]       clr_q;
	logic [AW-1:0]     base_q;

	// pipeline of one component: s1 = product + memory read, s2 = write
	logic               v_s1;
	logic [AW-1:0]      addr_s1;
	logic               rd_s1;
	logic [3:0]         comp_s1;
	logic signed [63:0] prod_s1;
	logic signed [63:0] rdata_s1;
	logic               wen;
	logic [AW-1:0]      waddr;
	logic signed [63:0] wdata;

	logic               ovalid_q;
	logic [11:0]        ocell_q;
	logic [3:0]         ocomp_q;
	logic signed [63:0] oval_q;
	logic               obad_q;
	logic               olast_q;

	logic               issue;
	logic               out_free;
	logic signed [17:0] bsel;
	logic signed [31:0] dsel;
	logic signed [49:0] prod_c;
	logic [AW-1:0]      addr_c;
	logic               take;

	assign out_free = !ovalid_q || rsp.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ctsa_pkg::ST_CLEAR: if (clr_q == (AW+1)'(DEPTH - 1)) state_d = ctsa_pkg::ST_IDLE;
			ctsa_pkg::ST_IDLE: begin
				if (take && !job.bad) state_d = job.is_read ? ctsa_pkg::ST_READ
					: ctsa_pkg::ST_ACC;
			end
			ctsa_pkg::ST_ACC: if (comp_q == 4'd8) state_d = ctsa_pkg::ST_IDLE;
			ctsa_pkg::ST_READ: if (issue && comp_q == 4'd8) state_d = ctsa_pkg::ST_IDLE;
			default: state_d = ctsa_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		job_ready = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			ctsa_pkg::ST_IDLE: job_ready = !v_s1 && (!job.bad || out_free);
			ctsa_pkg::ST_ACC: issue = 1'b1;
			ctsa_pkg::ST_READ: issue = out_free && !v_s1;
			default: ;
		endcase
	end
	assign take = job_valid && job_ready;

	// Operand selection for component m*3+n
	always_comb begin
		unique case (comp_q)
			4'd0, 4'd1, 4'd2: bsel = cur_q.b_x;
			4'd3, 4'd4, 4'd5: bsel = cur_q.b_y;
			default: bsel = cur_q.b_z;
		endcase
		unique case (comp_q)
			4'd0, 4'd3, 4'd6: dsel = cur_q.dl_x;
			4'd1, 4'd4, 4'd7: dsel = cur_q.dl_y;
			default: dsel = cur_q.dl_z;
		endcase
		prod_c = bsel * dsel;
		addr_c = base_q + AW'(comp_q);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctsa_pkg::ST_CLEAR;
			clr_q <= '0;
			comp_q <= '0;
			v_s1 <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ctsa_pkg::ST_CLEAR) clr_q <= clr_q + (AW+1)'(1);
			if (take) comp_q <= '0;
			else if (issue) comp_q <= comp_q + 4'd1;
			v_s1 <= issue;
			if ((take && job.bad) || (v_s1 && rd_s1)) ovalid_q <= 1'b1;
			else if (rsp.ready) ovalid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= job;
			base_q <= AW'(job.cell_num[CW-1:0]) * AW'(ctsa_pkg::NUM_COMP);
		end
		if (issue) begin
			addr_s1 <= addr_c;
			rd_s1 <= cur_q.is_read;
			comp_s1 <= comp_q;
			prod_s1 <= 64'(prod_c);
		end
		if (take && job.bad) begin
			ocell_q <= '0;
			ocomp_q <= '0;
			oval_q <= '0;
			obad_q <= 1'b1;
			olast_q <= 1'b1;
		end else if (v_s1 && rd_s1) begin
			ocell_q <= cur_q.cell_num[11:0];
			ocomp_q <= comp_s1;
			oval_q <= rdata_s1;
			obad_q <= 1'b0;
			olast_q <= (comp_s1 == 4'd8);
		end
	end

	// Write port: clear sweep, readout clear, or accumulate
	always_comb begin
		wen = 1'b0;
		waddr = addr_s1;
		wdata = '0;
		if (state_q == ctsa_pkg::ST_CLEAR) begin
			wen = 1'b1;
			waddr = clr_q[AW-1:0];
		end else if (v_s1) begin
			wen = 1'b1;
			wdata = rd_s1 ? 64'sd0 : ctsa_pkg::sat_add(rdata_s1, prod_s1);
		end
	end

	// Store: registered read at issue, write in the following cycle
	always_ff @(posedge clk) begin
		if (issue) rdata_s1 <= mem[addr_c];
		if (wen) mem[waddr] <= wdata;
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.cell_number  = ocell_q;
	assign rsp.component    = ocomp_q;
	assign rsp.tensor_value = oval_q;
	assign rsp.bad_cell     = obad_q;
	assign rsp.last         = olast_q;

	// Accumulate never drives a reply
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctsa_pkg::ST_ACC) |-> !(v_s1 && rd_s1))
		else $error("ctsa_back: bad accumulate reply");
	// No issue and no request taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctsa_pkg::ST_CLEAR) |-> (!issue && !job_ready))
		else $error("ctsa_back: issue during clear");
	// A readout never overwrites a pending reply
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !rsp.ready) |=> $stable(oval_q))
		else $error("ctsa_back: reply overwritten");

endmodule

@@ rtl/cell_tensor_scatter_accumulate_unit.sv @@
// Accumulate: through the front register and queue, then the back end takes the
// request, does one store read-modify-write per component and drains the last
// write before the next request. Readout: 9 replies; each component is read,
// then output-registered, and the next read waits for a free reply register.
// Bad cell: one reply, loaded when the back end takes it. Reset sets control
// registers; the back end waits while a sweep zeroes all MAX_CELLS*9 entries.
// ----------------------------------------------------------------------------
// cell_tensor_scatter_accumulate_unit: top level
// Configuration registers, front classifier, queue and back-end sequencer.
// ----------------------------------------------------------------------------
module cell_tensor_scatter_accumulate_unit #(
	parameter int unsigned MAX_CELLS = 4096,
	parameter int unsigned DIM_MAX   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ctsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	ctsa_req_if.sink                            req,
	ctsa_rsp_if.source                          rsp
);

	logic [4:0]  cells_x_q, cells_y_q, cells_z_q;
	logic [31:0] box_x_q, box_y_q, box_z_q;
	logic           f_valid, f_ready, q_valid, q_ready;
	ctsa_pkg::job_t f_job, q_job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= 5'd16;
			cells_y_q <= 5'd16;
			cells_z_q <= 5'd16;
			box_x_q <= '0;
			box_y_q <= '0;
			box_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctsa_pkg::REG_CELLS_X: cells_x_q <= cfg_data[4:0];
				ctsa_pkg::REG_CELLS_Y: cells_y_q <= cfg_data[4:0];
				ctsa_pkg::REG_CELLS_Z: cells_z_q <= cfg_data[4:0];
				ctsa_pkg::REG_BOX_X: box_x_q <= cfg_data;
				ctsa_pkg::REG_BOX_Y: box_y_q <= cfg_data;
				ctsa_pkg::REG_BOX_Z: box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ctsa_front #(.MAX_CELLS(MAX_CELLS), .DIM_MAX(DIM_MAX)) u_front (
		.clk, .arst_n, .req,
		.cells_x(cells_x_q), .cells_y(cells_y_q), .cells_z(cells_z_q),
		.box_x(box_x_q), .box_y(box_y_q), .box_z(box_z_q),
		.job_valid(f_valid), .job(f_job), .job_ready(f_ready)
	);

	ctsa_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_job(f_job), .in_ready(f_ready),
		.out_valid(q_valid), .out_job(q_job), .out_ready(q_ready)
	);

	ctsa_back #(.MAX_CELLS(MAX_CELLS)) u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job(q_job), .job_ready(q_ready), .rsp
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the cell tensor scatter-accumulator
// Drives accumulate and readout requests through random idling on both
// channels. A local shadow of the per-cell tensors predicts every reply, and
// each reply is compared with the oldest pending one.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned MAX_CELLS = 4096;
	localparam int unsigned DIM_MAX   = 16;
	localparam int unsigned WATCHDOG  = 150000;
	localparam logic [ctsa_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [ctsa_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic signed [31:0] D_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] D_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [17:0] B_MIN = 18'sh2_0000;
	localparam logic signed [17:0] B_MAX = 18'sh1_FFFF;

	typedef struct {
		ctsa_pkg::req_type_t kind;
		logic [3:0]         cx, cy, cz;
		logic signed [31:0] dx, dy, dz;
		logic signed [17:0] bx, by, bz;
	} seg_req_t;

	typedef struct {
		logic [11:0]        cell_no;
		logic [3:0]         comp;
		logic signed [63:0] value;
		logic               bad;
		logic               last;
	} tensor_entry_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ctsa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ctsa_pkg::CFG_DATA_W-1:0] cfg_data;

	ctsa_req_if req ();
	ctsa_rsp_if rsp ();

	cell_tensor_scatter_accumulate_unit #(
		.MAX_CELLS(MAX_CELLS),
		.DIM_MAX(DIM_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Shadow state
	longint tensor_sum[int];
	logic [4:0] grid_x, grid_y, grid_z;
	logic [31:0] box_x, box_y, box_z;
	tensor_entry_t pending_q[$];

	int n_fail, n_replies, n_accum, n_reads, n_bad;
	bit idle_en;
	int unsigned quiet_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------------------------------------------------------- model
	function automatic longint fold_axis(logic signed [31:0] d, logic [31:0] len);
		longint dd, l;
		dd = d;
		l = longint'(len);
		if (l == 0) return dd;
		if (2 * dd > l) return dd - l;
		if (2 * dd < -l) return dd + l;
		return dd;
	endfunction

	function automatic longint add_clamped(longint a, longint b);
		logic signed [64:0] s;
		s = a;
		s = s + b;
		if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic int unsigned axis_count(logic [4:0] n);
		return (n > DIM_MAX) ? DIM_MAX : n;
	endfunction

	// Work out the replies one request causes and update the shadow tensors
	function automatic void predict_tensor(seg_req_t r);
		int unsigned nx, ny, nz, lin, idx;
		longint dl[3], b[3], v;
		tensor_entry_t e;
		nx = axis_count(grid_x);
		ny = axis_count(grid_y);
		nz = axis_count(grid_z);
		lin = r.cz + nz * r.cy + nz * ny * r.cx;
		if (r.cx >= nx || r.cy >= ny || r.cz >= nz || lin >= MAX_CELLS) begin
			e = '{cell_no: 12'd0, comp: 4'd0, value: 64'sd0, bad: 1'b1, last: 1'b1};
			pending_q.push_back(e);
			n_bad++;
			return;
		end
		if (r.kind == ctsa_pkg::REQ_READ) begin
			n_reads++;
			for (int m = 0; m < ctsa_pkg::NUM_COMP; m++) begin
				idx = lin * ctsa_pkg::NUM_COMP + m;
				v = tensor_sum.exists(idx) ? tensor_sum[idx] : 0;
				e = '{cell_no: lin[11:0], comp: m[3:0], value: v, bad: 1'b0,
					last: (m == ctsa_pkg::NUM_COMP - 1)};
				pending_q.push_back(e);
				tensor_sum.delete(idx);
			end
			return;
		end
		n_accum++;
		dl[0] = fold_axis(r.dx, box_x);
		dl[1] = fold_axis(r.dy, box_y);
		dl[2] = fold_axis(r.dz, box_z);
		b[0] = r.bx;
		b[1] = r.by;
		b[2] = r.bz;
		for (int m = 0; m < 3; m++)
			for (int n = 0; n < 3; n++) begin
				idx = lin * ctsa_pkg::NUM_COMP + m * 3 + n;
				v = tensor_sum.exists(idx) ? tensor_sum[idx] : 0;
				tensor_sum[idx] = add_clamped(v, b[m] * dl[n]);
			end
	endfunction

	// ---------------------------------------------------------------- checks
	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		n_fail++;
	endtask

	// A reply is taken at the next rising edge when valid and ready are high now
	always @(negedge clk) begin
		tensor_entry_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_replies++;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected reply cell %0d comp %0d",
					rsp.cell_number, rsp.component));
			end else begin
				e = pending_q.pop_front();
				if (rsp.cell_number !== e.cell_no)
					report_mismatch($sformatf("cell_number %0d, want %0d",
						rsp.cell_number, e.cell_no));
				if (rsp.component !== e.comp)
					report_mismatch($sformatf("component %0d, want %0d",
						rsp.component, e.comp));
				if (rsp.tensor_value !== e.value)
					report_mismatch($sformatf("cell %0d comp %0d value %0d, want %0d",
						e.cell_no, e.comp, rsp.tensor_value, e.value));
				if (rsp.bad_cell !== e.bad)
					report_mismatch($sformatf("bad_cell %0b, want %0b", rsp.bad_cell, e.bad));
				if (rsp.last !== e.last)
					report_mismatch($sformatf("last %0b, want %0b", rsp.last, e.last));
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(negedge clk) begin
		if (arst_n && ((req.valid && req.ready) || (rsp.valid && rsp.ready)))
			quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d replies pending", pending_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Reply side: random stall bursts
	always @(posedge clk or negedge arst_n) begin
		int unsigned hold;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold = 0;
		end else if (hold > 0) begin
			hold--;
			rsp.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			hold = $urandom_range(0, 10);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- drivers
	task automatic write_reg(input logic [ctsa_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			ctsa_pkg::REG_CELLS_X: grid_x = val[4:0];
			ctsa_pkg::REG_CELLS_Y: grid_y = val[4:0];
			ctsa_pkg::REG_CELLS_Z: grid_z = val[4:0];
			ctsa_pkg::REG_BOX_X:   box_x = val;
			ctsa_pkg::REG_BOX_Y:   box_y = val;
			ctsa_pkg::REG_BOX_Z:   box_z = val;
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [4:0] nx, ny, nz);
		write_reg(ctsa_pkg::REG_CELLS_X, {27'd0, nx});
		write_reg(ctsa_pkg::REG_CELLS_Y, {27'd0, ny});
		write_reg(ctsa_pkg::REG_CELLS_Z, {27'd0, nz});
	endtask

	task automatic set_box(input logic [31:0] lx, ly, lz);
		write_reg(ctsa_pkg::REG_BOX_X, lx);
		write_reg(ctsa_pkg::REG_BOX_Y, ly);
		write_reg(ctsa_pkg::REG_BOX_Z, lz);
	endtask

	// Offer one request, optionally after an idle burst, until it is taken
	task automatic send_request(input seg_req_t r);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.cell_x <= r.cx;
		req.cell_y <= r.cy;
		req.cell_z <= r.cz;
		req.delta_x <= r.dx;
		req.delta_y <= r.dy;
		req.delta_z <= r.dz;
		req.burg_x <= r.bx;
		req.burg_y <= r.by;
		req.burg_z <= r.bz;
		do @(negedge clk); while (!req.ready);
		predict_tensor(r);
		@(posedge clk);
	endtask

	// Let every pending reply come back, then let queued segments finish
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic seg_req_t seg(ctsa_pkg::req_type_t k, logic [3:0] x, y, z,
			logic signed [31:0] dx, dy, dz, logic signed [17:0] bx, by, bz);
		seg_req_t r;
		r = '{kind: k, cx: x, cy: y, cz: z, dx: dx, dy: dy, dz: dz, bx: bx, by: by, bz: bz};
		return r;
	endfunction

	function automatic seg_req_t read_of(logic [3:0] x, y, z);
		return seg(ctsa_pkg::REQ_READ, x, y, z, 32'sd0, 32'sd0, 32'sd0,
			18'sd0, 18'sd0, 18'sd0);
	endfunction

	function automatic logic signed [31:0] rand_delta();
		case ($urandom_range(0, 5))
			0: return D_MIN;
			1: return D_MAX;
			2: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [17:0] rand_burg();
		case ($urandom_range(0, 4))
			0: return B_MIN;
			1: return B_MAX;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] rand_index(logic [4:0] n);
		int unsigned top;
		top = axis_count(n);
		if ($urandom_range(0, 9) == 0 || top == 0) return 4'($urandom);
		return 4'($urandom_range(0, (top > 3) ? 2 : top - 1));
	endfunction

	// Mostly segments on a few cells, with readouts and stray cells mixed in
	function automatic seg_req_t rand_request();
		seg_req_t r;
		r.kind = ($urandom_range(0, 4) == 0) ? ctsa_pkg::REQ_READ : ctsa_pkg::REQ_ACCUM;
		r.cx = rand_index(grid_x);
		r.cy = rand_index(grid_y);
		r.cz = rand_index(grid_z);
		r.dx = rand_delta();
		r.dy = rand_delta();
		r.dz = rand_delta();
		r.bx = rand_burg();
		r.by = rand_burg();
		r.bz = rand_burg();
		return r;
	endfunction

	// ---------------------------------------------------------------- tests
	task automatic test_default_grid();
		send_request(read_of(4'd0, 4'd0, 4'd0));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd0, 4'd0, 4'd0, D_MAX, D_MIN, 32'sd1,
			B_MAX, B_MIN, -18'sd1));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd0, 4'd0, 4'd0, D_MIN, D_MIN, D_MIN,
			B_MIN, B_MIN, B_MIN));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd15, 4'd15, 4'd15, D_MAX, D_MAX, D_MAX,
			B_MAX, B_MAX, B_MAX));
		send_request(read_of(4'd0, 4'd0, 4'd0));
		send_request(read_of(4'd0, 4'd0, 4'd0));
		send_request(read_of(4'd15, 4'd15, 4'd15));
		drain();
	endtask

	task automatic test_grid_limits();
		set_grid(5'd3, 5'd5, 5'd7);
		// unused indexes must leave the grid alone
		write_reg(IDX_SPARE_LO, 32'd1);
		write_reg(IDX_SPARE_HI, 32'd1);
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd2, 4'd4, 4'd6, 32'sh1_0000, -32'sh2_0000,
			32'sh8000, 18'sh1_0000, -18'sh8000, 18'sh4000));
		send_request(read_of(4'd2, 4'd4, 4'd6));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd3, 4'd0, 4'd0, D_MAX, 32'sd0, 32'sd0,
			B_MAX, 18'sd0, 18'sd0));
		send_request(read_of(4'd0, 4'd5, 4'd0));
		send_request(read_of(4'd0, 4'd0, 4'd7));
		drain();
		// a zero count rejects every cell
		set_grid(5'd0, 5'd16, 5'd16);
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd0, 4'd0, 4'd0, D_MAX, 32'sd0, 32'sd0,
			B_MAX, 18'sd0, 18'sd0));
		send_request(read_of(4'd0, 4'd0, 4'd0));
		drain();
		// counts above the grid limit clamp to it
		set_grid(5'd31, 5'd31, 5'd31);
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd15, 4'd15, 4'd15, 32'sh3_0000, 32'sh1,
			-32'sh1, B_MIN, B_MAX, 18'sd3));
		send_request(read_of(4'd15, 4'd15, 4'd15));
		drain();
	endtask

	task automatic test_periodic_box();
		set_grid(5'd2, 5'd2, 5'd2);
		set_box(32'h0004_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		// ties at half a box stay, one step past folds
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd1, 4'd1, 4'd1, 32'sh2_0000, 32'sh7FFF_FFFF,
			32'sd1, B_MAX, B_MAX, B_MAX));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd1, 4'd1, 4'd1, -32'sh2_0000, D_MIN,
			-32'sd1, B_MIN, B_MIN, B_MIN));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd1, 4'd1, 4'd1, 32'sh2_0001, 32'sh7FFF_FFFF,
			32'sd2, 18'sh1_0000, -18'sh1_0000, 18'sh1));
		send_request(seg(ctsa_pkg::REQ_ACCUM, 4'd1, 4'd1, 4'd1, -32'sh2_0001,
			-32'sh7FFF_FFFF, -32'sd2, 18'sh1_0000, -18'sh1_0000, 18'sh1));
		send_request(read_of(4'd1, 4'd1, 4'd1));
		drain();
	endtask

	task automatic test_random_traffic(input int items, input bit pause_midway);
		for (int i = 0; i < items; i++) begin
			if (pause_midway && i == items / 2) drain();
			send_request(rand_request());
		end
		// empty the low-index cells most requests touch so later phases start from known sums
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				for (int z = 0; z < 3; z++)
					send_request(read_of(4'(x), 4'(y), 4'(z)));
		drain();
	endtask

	// ---------------------------------------------------------------- main
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ctsa_pkg::REG_CELLS_X;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = ctsa_pkg::REQ_ACCUM;
		{req.cell_x, req.cell_y, req.cell_z} = '0;
		{req.delta_x, req.delta_y, req.delta_z} = '0;
		{req.burg_x, req.burg_y, req.burg_z} = '0;
		grid_x = 5'd16;
		grid_y = 5'd16;
		grid_z = 5'd16;
		box_x = '0;
		box_y = '0;
		box_z = '0;
		idle_en = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_grid();
		test_grid_limits();
		test_periodic_box();

		set_grid(5'd3, 5'd4, 5'd2);
		set_box(32'h0010_0000, 32'h0000_0000, 32'h8000_0000);
		test_random_traffic(70, 1'b1);

		set_grid(5'd1, 5'd1, 5'd1);
		set_box(32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000);
		test_random_traffic(60, 1'b0);

		set_grid(5'd16, 5'd16, 5'd16);
		set_box(32'h0000_0000, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
		test_random_traffic(70, 1'b0);

		// closing stretch at full rate
		idle_en = 1'b0;
		set_grid(5'd2, 5'd3, 5'd3);
		set_box($urandom, $urandom, $urandom);
		test_random_traffic(90, 1'b0);

		$display("covered %0d segments, %0d readouts, %0d rejected cells, %0d replies",
			n_accum, n_reads, n_bad, n_replies);
		$display("grid counts zero to over-limit, box lengths zero to full scale");
		if (n_fail == 0 && pending_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
